### rtl/dgrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgrc_pkg
// Shared types, fixed-point constants and the sigmoid table generator for
// the decay-gated recurrent cell.
// ----------------------------------------------------------------------------
package dgrc_pkg;

  // Q4.12 signed values, Q0.16 unsigned sigmoid
  localparam int VALUE_W     = 16;
  localparam int FRAC_BITS   = VALUE_W - 4;
  localparam int RANGE_SHIFT = FRAC_BITS + 3;   // 8.0 in value units
  localparam int SIG_W       = 16;
  localparam int ARG_W       = VALUE_W + 1;     // sum of two values

  typedef struct packed {
    logic signed [VALUE_W-1:0] gate_logit;
    logic signed [VALUE_W-1:0] gate_bias;
    logic signed [VALUE_W-1:0] new_value;
    logic signed [VALUE_W-1:0] value_bias;
    logic signed [VALUE_W-1:0] previous_hidden;
  } dgrc_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] next_hidden;
    logic        [SIG_W-1:0]   decay_factor;
    logic signed [VALUE_W-1:0] gated_output;
  } dgrc_out_t;

  // Elaboration-time unsigned quotient by shift and subtract.
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned dvs);
    longint unsigned quo;
    longint unsigned rem;
    int              b;
    quo = '0;
    rem = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= dvs) begin
        rem    = rem - dvs;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Table point k of depth: sigmoid(8k/depth) in Q0.16.
  // Elaboration-time only: exp(-k/depth) by Taylor series in Q30,
  // squared three times, then 1/(1+e) with round half up.
  function automatic logic [SIG_W-1:0] sig_point(input int unsigned k,
                                                  input int unsigned depth);
    longint unsigned q30;
    longint unsigned u;
    longint unsigned term;
    longint unsigned div_v;
    longint unsigned e;
    longint unsigned den;
    longint unsigned q;
    longint          sum_v;
    int              j;
    int              s;
    q30   = 64'd1 << 30;
    u     = udiv64(longint'(k) << 30, longint'(depth));
    sum_v = longint'(q30);
    term  = q30;
    for (j = 1; j <= 24 && term != 0; j++) begin
      div_v = longint'(j) * q30;
      term  = udiv64(term * u + (div_v >> 1), div_v);
      if (j[0]) begin
        sum_v = sum_v - longint'(term);
      end else begin
        sum_v = sum_v + longint'(term);
      end
    end
    if (sum_v < 0) begin
      sum_v = 0;
    end
    e = longint'(sum_v);
    for (s = 0; s < 3; s++) begin
      e = (e * e + (64'd1 << 29)) >> 30;
    end
    den = q30 + e;
    q   = udiv64((64'd1 << 46) + (den >> 1), den);
    if (q > 64'd65535) begin
      q = 64'd65535;
    end
    return q[SIG_W-1:0];
  endfunction

endpackage

### rtl/dgrc_sigmoid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgrc_sigmoid
// Four-stage table sigmoid with linear interpolation: index, table read,
// slope multiply, round and sign fold. Side data rides along unchanged.
// ----------------------------------------------------------------------------
module dgrc_sigmoid #(
  parameter int DEPTH  = 256,
  parameter int SIDE_W = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [dgrc_pkg::ARG_W-1:0] x,
  input  logic [SIDE_W-1:0]                 in_side,
  output logic                              out_valid,
  output logic [dgrc_pkg::SIG_W-1:0]        y,
  output logic [SIDE_W-1:0]                 out_side
);

  localparam int RS    = dgrc_pkg::RANGE_SHIFT;
  localparam int SW    = dgrc_pkg::SIG_W;
  localparam int AW    = dgrc_pkg::ARG_W;
  localparam int IDX_W = $clog2(DEPTH + 1);
  localparam int POS_W = RS + IDX_W;

  // constant table, DEPTH+1 points
  logic [SW-1:0] rom [0:DEPTH];
  for (genvar k = 0; k <= DEPTH; k++) begin : g_rom
    localparam logic [SW-1:0] PT = dgrc_pkg::sig_point(k, DEPTH);
    assign rom[k] = PT;
  end

  // ---- stage A: magnitude, clamp to 8.0, table position
  logic [AW-1:0]    mag;
  logic [RS:0]      a_clamp;
  logic [POS_W-1:0] pos;

  logic              va_r;
  logic              neg_a_r;
  logic [IDX_W-1:0]  idx_a_r;
  logic [RS-1:0]     rem_a_r;
  logic [SIDE_W-1:0] side_a_r;

  always_comb begin
    mag     = x[AW-1] ? AW'(-x) : AW'(x);
    a_clamp = (mag > (AW'(1) << RS)) ? (RS+1)'(1) << RS : mag[RS:0];
    pos     = POS_W'(a_clamp) * POS_W'(DEPTH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_a_r  <= x[AW-1];
      idx_a_r  <= pos[RS +: IDX_W];
      rem_a_r  <= pos[RS-1:0];
      side_a_r <= in_side;
    end
  end

  // ---- stage B: read both neighbors; at the table end both are the last point
  logic [IDX_W-1:0] idx_hi;

  logic              vb_r;
  logic              neg_b_r;
  logic [RS-1:0]     rem_b_r;
  logic [SW-1:0]     s_lo_b_r;
  logic [SW-1:0]     s_hi_b_r;
  logic [SIDE_W-1:0] side_b_r;

  assign idx_hi = (idx_a_r == IDX_W'(DEPTH)) ? idx_a_r : idx_a_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_b_r  <= neg_a_r;
      rem_b_r  <= rem_a_r;
      s_lo_b_r <= rom[idx_a_r];
      s_hi_b_r <= rom[idx_hi];
      side_b_r <= side_a_r;
    end
  end

  // ---- stage C: slope times remainder
  logic signed [SW:0]      slope;
  logic signed [SW+RS+1:0] prod_nxt;

  logic                    vc_r;
  logic                    neg_c_r;
  logic [SW-1:0]           s_lo_c_r;
  logic signed [SW+RS+1:0] prod_c_r;
  logic [SIDE_W-1:0]       side_c_r;

  always_comb begin
    slope    = $signed({1'b0, s_hi_b_r}) - $signed({1'b0, s_lo_b_r});
    prod_nxt = slope * $signed({1'b0, rem_b_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_c_r  <= neg_b_r;
      s_lo_c_r <= s_lo_b_r;
      prod_c_r <= prod_nxt;
      side_c_r <= side_b_r;
    end
  end

  // ---- stage D: round, add base, fold for negative argument, clamp
  logic signed [SW+RS+1:0] rnd_full;
  logic signed [SW+2:0]    s_pos;
  logic signed [SW+2:0]    s_fold;
  logic [SW-1:0]           y_nxt;

  logic              vd_r;
  logic [SW-1:0]     y_r;
  logic [SIDE_W-1:0] side_d_r;

  always_comb begin
    rnd_full = (prod_c_r + (SW+RS+2)'(1 << (RS - 1))) >>> RS;
    s_pos    = $signed({3'b000, s_lo_c_r}) + (SW+3)'(rnd_full);
    s_fold   = neg_c_r ? ((SW+3)'(1) << SW) - s_pos : s_pos;
    if (s_fold < 0) begin
      y_nxt = '0;
    end else if (s_fold > $signed({3'b000, {SW{1'b1}}})) begin
      y_nxt = '1;
    end else begin
      y_nxt = s_fold[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (en) begin
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_r      <= y_nxt;
      side_d_r <= side_c_r;
    end
  end

  assign out_valid = vd_r;
  assign y         = y_r;
  assign out_side  = side_d_r;

endmodule

### rtl/dgrc_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgrc_blend
// Two-stage hidden update: h = sat(round((a*hp + (1-a)*v) / 2^16)).
// ----------------------------------------------------------------------------
module dgrc_blend (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [dgrc_pkg::SIG_W-1:0]          alpha,
  input  logic signed [dgrc_pkg::VALUE_W-1:0] prev_h,
  input  logic signed [dgrc_pkg::ARG_W-1:0]   cand,
  output logic                                out_valid,
  output logic signed [dgrc_pkg::VALUE_W-1:0] hidden,
  output logic [dgrc_pkg::SIG_W-1:0]          alpha_out
);

  localparam int VW = dgrc_pkg::VALUE_W;
  localparam int SW = dgrc_pkg::SIG_W;
  localparam int AW = dgrc_pkg::ARG_W;
  localparam int P1_W = SW + 1 + VW;
  localparam int P2_W = SW + 2 + AW;
  localparam int SUM_W = P2_W + 1;

  // ---- stage 1: both products
  logic [SW:0]             one_minus;
  logic signed [P1_W-1:0]  p1_nxt;
  logic signed [P2_W-1:0]  p2_nxt;

  logic                   v1_r;
  logic signed [P1_W-1:0] p1_r;
  logic signed [P2_W-1:0] p2_r;
  logic [SW-1:0]          alpha1_r;

  always_comb begin
    one_minus = ((SW+1)'(1) << SW) - (SW+1)'(alpha);
    p1_nxt    = $signed({1'b0, alpha}) * prev_h;
    p2_nxt    = $signed({1'b0, one_minus}) * cand;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r     <= p1_nxt;
      p2_r     <= p2_nxt;
      alpha1_r <= alpha;
    end
  end

  // ---- stage 2: sum, round, saturate
  logic signed [SUM_W-1:0] sum_v;
  logic signed [SUM_W-1:0] shifted;
  logic signed [VW-1:0]    h_nxt;

  logic                 v2_r;
  logic signed [VW-1:0] h_r;
  logic [SW-1:0]        alpha2_r;

  always_comb begin
    sum_v   = SUM_W'(p1_r) + SUM_W'(p2_r) + (SUM_W'(1) << (SW - 1));
    shifted = sum_v >>> SW;
    if (shifted > SUM_W'((1 << (VW - 1)) - 1)) begin
      h_nxt = {1'b0, {(VW-1){1'b1}}};
    end else if (shifted < -(SUM_W'(1) << (VW - 1))) begin
      h_nxt = {1'b1, {(VW-1){1'b0}}};
    end else begin
      h_nxt = shifted[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_r      <= h_nxt;
      alpha2_r <= alpha1_r;
    end
  end

  assign out_valid = v2_r;
  assign hidden    = h_r;
  assign alpha_out = alpha2_r;

endmodule

### rtl/dgrc_silu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgrc_silu
// Four-stage self gate: silu = round(h*sig(h)/2^16), then
// g = sat(round(h*silu/2^12)). Last stage is the result register.
// ----------------------------------------------------------------------------
module dgrc_silu (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [dgrc_pkg::VALUE_W-1:0] hidden,
  input  logic [dgrc_pkg::SIG_W-1:0]          sig_h,
  input  logic [dgrc_pkg::SIG_W-1:0]          alpha,
  output logic                                out_valid,
  output dgrc_pkg::dgrc_out_t                 out_item
);

  localparam int VW  = dgrc_pkg::VALUE_W;
  localparam int SW  = dgrc_pkg::SIG_W;
  localparam int FB  = dgrc_pkg::FRAC_BITS;
  localparam int PA_W = VW + SW + 1;
  localparam int SL_W = PA_W - SW;
  localparam int PB_W = VW + SL_W;

  // ---- stage 1: h * sig(h)
  logic                   v1_r;
  logic signed [PA_W-1:0] pa_r;
  logic signed [VW-1:0]   h1_r;
  logic [SW-1:0]          alpha1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r     <= hidden * $signed({1'b0, sig_h});
      h1_r     <= hidden;
      alpha1_r <= alpha;
    end
  end

  // ---- stage 2: round to silu
  logic signed [PA_W-1:0] pa_rnd;

  logic                   v2_r;
  logic signed [SL_W-1:0] silu_r;
  logic signed [VW-1:0]   h2_r;
  logic [SW-1:0]          alpha2_r;

  assign pa_rnd = (pa_r + (PA_W'(1) << (SW - 1))) >>> SW;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      silu_r   <= pa_rnd[SL_W-1:0];
      h2_r     <= h1_r;
      alpha2_r <= alpha1_r;
    end
  end

  // ---- stage 3: h * silu
  logic                   v3_r;
  logic signed [PB_W-1:0] pb_r;
  logic signed [VW-1:0]   h3_r;
  logic [SW-1:0]          alpha3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pb_r     <= h2_r * silu_r;
      h3_r     <= h2_r;
      alpha3_r <= alpha2_r;
    end
  end

  // ---- stage 4: round, saturate, result register
  logic signed [PB_W-1:0] pb_rnd;
  logic signed [VW-1:0]   g_nxt;

  logic                v4_r;
  dgrc_pkg::dgrc_out_t item_r;

  always_comb begin
    pb_rnd = (pb_r + (PB_W'(1) << (FB - 1))) >>> FB;
    if (pb_rnd > PB_W'((1 << (VW - 1)) - 1)) begin
      g_nxt = {1'b0, {(VW-1){1'b1}}};
    end else if (pb_rnd < -(PB_W'(1) << (VW - 1))) begin
      g_nxt = {1'b1, {(VW-1){1'b0}}};
    end else begin
      g_nxt = pb_rnd[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r.next_hidden  <= h3_r;
      item_r.decay_factor <= alpha3_r;
      item_r.gated_output <= g_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_item  = item_r;

endmodule

### rtl/decay_gated_recurrent_cell_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decay_gated_recurrent_cell_core
// Streaming forward step of a decay-gated recurrent cell, one element per
// transfer: alpha = sigmoid(logit + bias_a), h = alpha*h_prev + (1-alpha)*v,
// gated = h*h*sigmoid(h), all in Q4.12 with Q0.16 alpha.
//
// Channels: in_valid/in_stall/in_data carries one dgrc_in_t per transfer;
// out_valid/out_stall/out_data returns one dgrc_out_t per input transfer,
// in order. No configuration, no state between items.
// Pipeline, input to result: input add stage, 4-stage sigmoid, 2-stage
// blend, 4-stage sigmoid, 4-stage self gate.
// Throughput: one transfer per cycle while out_stall does not hold the
// pipeline; every stage is a register and the two table sigmoids are
// separate instances, so nothing is shared.
// Stall: the whole pipeline holds while out_valid is up and out_stall is
// high; in_stall is raised in exactly those cycles. Bubbles travel as
// cleared valid bits, so nothing is dropped or duplicated.
// Reset: rst_n low clears every valid bit; the pipeline comes up empty
// and ready once reset is released.
// SIGMOID_TABLE_DEPTH sets the sigmoid table size (depth+1 points).
// ----------------------------------------------------------------------------
module decay_gated_recurrent_cell_core #(
  parameter int SIGMOID_TABLE_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dgrc_pkg::dgrc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dgrc_pkg::dgrc_out_t out_data
);

  localparam int VW = dgrc_pkg::VALUE_W;
  localparam int SW = dgrc_pkg::SIG_W;
  localparam int AW = dgrc_pkg::ARG_W;
  localparam int SIDE1_W = AW + VW;   // candidate value, previous hidden
  localparam int SIDE2_W = VW + SW;   // hidden, alpha

  // global advance: hold everything only while a result waits and is stalled
  logic pipe_en;
  logic res_valid;

  assign pipe_en  = !(res_valid && out_stall);
  assign in_stall = !pipe_en;

  // ---- input stage: bias adds at full width
  logic                 v0_r;
  logic signed [AW-1:0] logit_r;
  logic signed [AW-1:0] cand_r;
  logic signed [VW-1:0] prev_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (pipe_en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      logit_r  <= AW'(in_data.gate_logit) + AW'(in_data.gate_bias);
      cand_r   <= AW'(in_data.new_value) + AW'(in_data.value_bias);
      prev_h_r <= in_data.previous_hidden;
    end
  end

  // ---- decay gate sigmoid
  logic               alpha_valid;
  logic [SW-1:0]      alpha;
  logic [SIDE1_W-1:0] side1_out;

  dgrc_sigmoid #(
    .DEPTH  (SIGMOID_TABLE_DEPTH),
    .SIDE_W (SIDE1_W)
  ) u_sig_gate (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (v0_r),
    .x         (logit_r),
    .in_side   ({cand_r, prev_h_r}),
    .out_valid (alpha_valid),
    .y         (alpha),
    .out_side  (side1_out)
  );

  // ---- hidden update
  logic                 h_valid;
  logic signed [VW-1:0] hidden;
  logic [SW-1:0]        alpha_h;

  dgrc_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (alpha_valid),
    .alpha     (alpha),
    .prev_h    (side1_out[VW-1:0]),
    .cand      (side1_out[SIDE1_W-1:VW]),
    .out_valid (h_valid),
    .hidden    (hidden),
    .alpha_out (alpha_h)
  );

  // ---- sigmoid of the new hidden value
  logic               sh_valid;
  logic [SW-1:0]      sig_h;
  logic [SIDE2_W-1:0] side2_out;

  dgrc_sigmoid #(
    .DEPTH  (SIGMOID_TABLE_DEPTH),
    .SIDE_W (SIDE2_W)
  ) u_sig_hidden (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (h_valid),
    .x         (AW'(hidden)),
    .in_side   ({hidden, alpha_h}),
    .out_valid (sh_valid),
    .y         (sig_h),
    .out_side  (side2_out)
  );

  // ---- self gate and result register
  dgrc_silu u_silu (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (sh_valid),
    .hidden    (side2_out[SIDE2_W-1:SW]),
    .sig_h     (sig_h),
    .alpha     (side2_out[SW-1:0]),
    .out_valid (res_valid),
    .out_item  (out_data)
  );

  assign out_valid = res_valid;

endmodule
